// ----- sv/omtt_pkg.sv -----
// Shared types and constants of the oven menu, timer and thermostat controller.
// Depends on nothing; used by sv/oven_menu_timer_thermostat.sv.

package omtt_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_BUTTON = 2'd0,
        OP_ENCODER = 2'd1,
        OP_TICK = 2'd2,
        OP_SENSOR = 2'd3
    } op_t;

    // Menu selections
    typedef enum logic [1:0] {
        MENU_TEMP = 2'd0,
        MENU_TIME = 2'd1,
        MENU_POWER = 2'd2,
        MENU_NONE = 2'd3
    } menu_t;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET_MIN = 3'd0;
    localparam logic [2:0] REG_TARGET_MAX = 3'd1;
    localparam logic [2:0] REG_MINUTES_MAX = 3'd2;
    localparam logic [2:0] REG_MINUTES_STEP = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE_MS = 3'd4;
    localparam logic [2:0] REG_SAFETY_CUTOFF = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int NOW_W = 32;
    localparam int ENC_W = 16;
    localparam int IR_W = 14;
    localparam int NTC_W = 13;
    localparam int DEG_W = 7;
    localparam int MIN_W = 14;
    localparam int STEP_W = 8;
    localparam int DEB_W = 16;
    localparam int SEC_W = 7;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 32;

    // Reset values of configuration and state
    localparam logic [DEG_W-1:0] TARGET_MIN_RST = 7'd10;
    localparam logic [DEG_W-1:0] TARGET_MAX_RST = 7'd45;
    localparam logic [MIN_W-1:0] MINUTES_MAX_RST = 14'd10000;
    localparam logic [STEP_W-1:0] MINUTES_STEP_RST = 8'd5;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic signed [NTC_W-1:0] CUTOFF_RST = 13'sd1280;

    localparam logic [DEG_W-1:0] TARGET_RST = 7'd24;
    localparam logic [MIN_W-1:0] MINUTES_RST = 14'd20;
    localparam logic signed [NTC_W-1:0] NTC_RST = 13'sd384;
    localparam logic [SEC_W-1:0] SECONDS_RELOAD = 7'd60;

endpackage

// ----- sv/oven_menu_timer_thermostat.sv -----
// Oven controller: button debounce and menu, encoder edits, minute countdown, heater decision.
// Depends on sv/omtt_pkg.sv (types, codes, widths and reset values).

// Every item on the s_ stream gives exactly one result item on the m_ stream. From acceptance to
// result, the input register captures the fields together with the encoder detent magnitude (a
// reciprocal multiply), then one pass of compares, adds and clamps updates the controller state
// and loads the result register. Both registers advance
// independently, so a new item is taken every cycle while results are taken every cycle; an
// item can still be accepted while a finished result waits for m_tready. The configuration
// port writes one register per cycle with cfg_we; write it only while no item is in flight.
module oven_menu_timer_thermostat #(
    parameter int TIME_BITS = 32,
    parameter int COUNTS_PER_DETENT = 4,
    parameter int TEMP_FRAC_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], button_level[32], encoder_count[48:33], ir_reading[62:49],
    // ntc_reading[75:63], zero fill [79:76]
    input  logic [omtt_pkg::S_DATA_W-1:0]       s_tdata,
    // operation[1:0]
    input  logic [1:0]                          s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // heater_on[0], oven_on[1], menu_now[3:2], target_now[10:4], minutes_now[24:11],
    // zero fill [31:25]
    output logic [omtt_pkg::M_DATA_W-1:0]       m_tdata,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [omtt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [omtt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Timestamps are compared modulo 2^TW
    localparam int TW = (TIME_BITS < omtt_pkg::NOW_W) ? TIME_BITS : omtt_pkg::NOW_W;
    // Truncating divide by COUNTS_PER_DETENT: (a * DIV_RECIP) >> DIV_SHIFT is exact for 16-bit a
    localparam int DIV_SHIFT = 20;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + COUNTS_PER_DETENT - 1) / COUNTS_PER_DETENT;
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam int PROD_W = omtt_pkg::ENC_W + RECIP_W;
    localparam int TGT_W = 17;

    // ---------------------------------------------------------------- configuration
    logic [omtt_pkg::DEG_W-1:0]          target_min_reg;
    logic [omtt_pkg::DEG_W-1:0]          target_max_reg;
    logic [omtt_pkg::MIN_W-1:0]          minutes_max_reg;
    logic [omtt_pkg::STEP_W-1:0]         minutes_step_reg;
    logic [omtt_pkg::DEB_W-1:0]          debounce_reg;
    logic signed [omtt_pkg::NTC_W-1:0]   cutoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_min_reg <= omtt_pkg::TARGET_MIN_RST;
            target_max_reg <= omtt_pkg::TARGET_MAX_RST;
            minutes_max_reg <= omtt_pkg::MINUTES_MAX_RST;
            minutes_step_reg <= omtt_pkg::MINUTES_STEP_RST;
            debounce_reg <= omtt_pkg::DEBOUNCE_RST;
            cutoff_reg <= omtt_pkg::CUTOFF_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                omtt_pkg::REG_TARGET_MIN: target_min_reg <= cfg_data[omtt_pkg::DEG_W-1:0];
                omtt_pkg::REG_TARGET_MAX: target_max_reg <= cfg_data[omtt_pkg::DEG_W-1:0];
                omtt_pkg::REG_MINUTES_MAX: minutes_max_reg <= cfg_data[omtt_pkg::MIN_W-1:0];
                omtt_pkg::REG_MINUTES_STEP: minutes_step_reg <= cfg_data[omtt_pkg::STEP_W-1:0];
                omtt_pkg::REG_DEBOUNCE_MS: debounce_reg <= cfg_data;
                omtt_pkg::REG_SAFETY_CUTOFF: cutoff_reg <= $signed(cfg_data[omtt_pkg::NTC_W-1:0]);
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic s_accept;

    // The result register frees up when empty or when its item is taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------- input stage
    logic [omtt_pkg::ENC_W-1:0]    enc_raw;
    logic [omtt_pkg::ENC_W-1:0]    enc_mag;
    logic [PROD_W-1:0]             enc_prod;
    logic [omtt_pkg::ENC_W-1:0]    enc_detents;

    assign enc_raw = s_tdata[48:33];
    // |count| fits 16 bits unsigned, including the most negative count
    assign enc_mag = enc_raw[omtt_pkg::ENC_W-1] ? (~enc_raw + 16'd1) : enc_raw;
    assign enc_prod = PROD_W'(enc_mag) * PROD_W'(DIV_RECIP);
    assign enc_detents = enc_prod[DIV_SHIFT +: omtt_pkg::ENC_W];

    omtt_pkg::op_t                     op_reg;
    logic [TW-1:0]                     now_reg;
    logic                              level_reg;
    logic                              enc_neg_reg;
    logic [omtt_pkg::ENC_W-1:0]        detents_reg;
    logic signed [omtt_pkg::IR_W-1:0]  ir_in_reg;
    logic signed [omtt_pkg::NTC_W-1:0] ntc_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= omtt_pkg::op_t'(s_tuser);
            now_reg <= s_tdata[TW-1:0];
            level_reg <= s_tdata[32];
            enc_neg_reg <= enc_raw[omtt_pkg::ENC_W-1];
            detents_reg <= enc_detents;
            ir_in_reg <= $signed(s_tdata[62:49]);
            ntc_in_reg <= $signed(s_tdata[75:63]);
        end
    end

    // ---------------------------------------------------------------- controller state
    omtt_pkg::menu_t                   menu_reg, menu_next;
    logic                              button_last_reg, button_last_next;
    logic [TW-1:0]                     button_time_reg, button_time_next;
    logic [omtt_pkg::DEG_W-1:0]        target_reg, target_next;
    logic [omtt_pkg::MIN_W-1:0]        minutes_reg, minutes_next;
    logic [omtt_pkg::SEC_W-1:0]        seconds_reg, seconds_next;
    logic                              active_reg, active_next;
    logic signed [omtt_pkg::IR_W-1:0]  ir_reg, ir_next;
    logic signed [omtt_pkg::NTC_W-1:0] ntc_reg, ntc_next;

    logic [TW-1:0]          btn_age;
    logic                   btn_take;
    logic signed [16:0]     inc;
    logic signed [17:0]     t_sum;
    logic signed [8:0]      step_s;
    logic signed [25:0]     m_prod;
    logic signed [26:0]     m_sum;
    logic [omtt_pkg::MIN_W-1:0] m_tick;
    logic signed [TGT_W-1:0] tgt_scaled;
    logic                   heat;

    always_comb begin
        menu_next = menu_reg;
        button_last_next = button_last_reg;
        button_time_next = button_time_reg;
        target_next = target_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        active_next = active_reg;
        ir_next = ir_reg;
        ntc_next = ntc_reg;

        btn_age = now_reg - button_time_reg;
        btn_take = (level_reg != button_last_reg) && (btn_age > TW'(debounce_reg));

        // Detents are minus count / COUNTS_PER_DETENT
        inc = enc_neg_reg ? $signed({1'b0, detents_reg}) : -$signed({1'b0, detents_reg});
        t_sum = $signed({11'd0, target_reg}) + 18'(inc);
        step_s = $signed({1'b0, minutes_step_reg});
        m_prod = 26'(inc) * 26'(step_s);
        m_sum = 27'(m_prod) + $signed({13'd0, minutes_reg});
        m_tick = minutes_reg;

        case (op_reg)
            omtt_pkg::OP_BUTTON: begin
                if (btn_take) begin
                    button_last_next = level_reg;
                    button_time_next = now_reg;
                    if (level_reg) begin
                        unique case (menu_reg)
                            omtt_pkg::MENU_TEMP: menu_next = omtt_pkg::MENU_TIME;
                            omtt_pkg::MENU_TIME: menu_next = omtt_pkg::MENU_POWER;
                            omtt_pkg::MENU_POWER: menu_next = omtt_pkg::MENU_TEMP;
                            default: menu_next = menu_reg;
                        endcase
                    end
                end
            end
            omtt_pkg::OP_ENCODER: begin
                unique case (menu_reg)
                    omtt_pkg::MENU_TEMP: begin
                        // Lower bound first, as it wins when the bounds cross
                        if (t_sum < $signed({11'd0, target_min_reg})) begin
                            target_next = target_min_reg;
                        end else if (t_sum > $signed({11'd0, target_max_reg})) begin
                            target_next = target_max_reg;
                        end else begin
                            target_next = t_sum[omtt_pkg::DEG_W-1:0];
                        end
                    end
                    omtt_pkg::MENU_TIME: begin
                        if (m_sum < 27'sd0) begin
                            minutes_next = '0;
                        end else if (m_sum > $signed({13'd0, minutes_max_reg})) begin
                            minutes_next = minutes_max_reg;
                        end else begin
                            minutes_next = m_sum[omtt_pkg::MIN_W-1:0];
                        end
                    end
                    omtt_pkg::MENU_POWER: begin
                        if (inc > 17'sd0) begin
                            active_next = 1'b1;
                        end else if (inc < 17'sd0) begin
                            active_next = 1'b0;
                        end
                    end
                    default: ;  // unreachable menu: hold
                endcase
            end
            omtt_pkg::OP_TICK: begin
                if (active_reg) begin
                    if (seconds_reg <= 7'd1) begin
                        if (minutes_reg != '0) begin
                            m_tick = minutes_reg - 14'd1;
                        end
                        seconds_next = omtt_pkg::SECONDS_RELOAD;
                    end else begin
                        seconds_next = seconds_reg - 7'd1;
                    end
                    if (m_tick > minutes_max_reg) begin
                        m_tick = minutes_max_reg;
                    end
                end
                minutes_next = m_tick;
                if (m_tick == '0) begin
                    active_next = 1'b0;
                end
            end
            default: begin
                ir_next = ir_in_reg;
                ntc_next = ntc_in_reg;
            end
        endcase

        // Heat only when on, below target on the IR reading and below the NTC cutoff
        tgt_scaled = $signed(TGT_W'(target_next) << TEMP_FRAC_BITS);
        heat = active_next && (tgt_scaled > TGT_W'(ir_next)) && (ntc_next < cutoff_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            menu_reg <= omtt_pkg::MENU_TEMP;
            button_last_reg <= 1'b1;
            button_time_reg <= '0;
            target_reg <= omtt_pkg::TARGET_RST;
            minutes_reg <= omtt_pkg::MINUTES_RST;
            seconds_reg <= '0;
            active_reg <= 1'b0;
            ir_reg <= '0;
            ntc_reg <= omtt_pkg::NTC_RST;
        end else if (advance) begin
            menu_reg <= menu_next;
            button_last_reg <= button_last_next;
            button_time_reg <= button_time_next;
            target_reg <= target_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            active_reg <= active_next;
            ir_reg <= ir_next;
            ntc_reg <= ntc_next;
        end
    end

    // ---------------------------------------------------------------- result register
    logic [omtt_pkg::M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {7'd0, minutes_next, target_next, menu_next, active_next, heat};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = m_data_reg;

    // ---------------------------------------------------------------- checks
    a_heat_needs_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("heater driven while the oven is off");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input refused without a blocked result");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    a_tick_no_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op_reg == omtt_pkg::OP_TICK) |=> minutes_reg <= $past(minutes_reg))
        else $error("minutes grew on a tick");

    a_seconds_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seconds_reg <= omtt_pkg::SECONDS_RELOAD)
        else $error("seconds counter out of range");

endmodule
